[rtl/wfg_pkg.sv]
// Shared types and constants for the wait-for graph deadlock detector.
`default_nettype none

package wfg_pkg;

  localparam int DefaultSlots = 32;
  localparam int SlotW        = 5;
  localparam int MaskW        = 32;
  localparam int InDataW      = 40;
  localparam int OutDataW     = 8;

  localparam logic ActAdd    = 1'b0;
  localparam logic ActCommit = 1'b1;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_DEADLOCK        = 2'd1,
    ST_ALREADY_WAITING = 2'd2,
    ST_COMMIT_WAITING  = 2'd3
  } status_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } wfg_res_t;

endpackage

`default_nettype wire

[rtl/wait_for_graph_deadlock_detector.sv]
// Top level of the wait-for graph deadlock detector with its result register.
//
//  Channel | Ports               | Content
//  --------+---------------------+-----------------------------------------------
//  input   | in_tvalid/in_tready | tuser: action; tdata: trx_slot, wait_mask
//  result  | out_tvalid/tready   | tdata: status
//
// Up to the result register, an add writes its row and then runs the cycle walk, reading at most
// SLOTS - 1 rows; a deadlock adds a sweep over all rows. A commit runs the sweep, and an item
// with an error status goes straight to the result. The next item is taken in the cycle after
// the result leaves the sequencer.
// Reset is synchronous and clears all slots at once through the present bits.
// A stalled result waits in the output register while the next item is taken.
`default_nettype none

module wait_for_graph_deadlock_detector #(
  parameter int SLOTS = wfg_pkg::DefaultSlots
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [wfg_pkg::InDataW-1:0]   in_tdata,   // trx_slot[4:0], wait_mask[36:5]
  input  wire logic                          in_tuser,   // action[0]
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [wfg_pkg::OutDataW-1:0]  out_tdata   // status[1:0]
);

  import wfg_pkg::*;

  localparam int SW = $clog2(SLOTS);

  wfg_res_t         res;
  logic             res_ready;
  logic             rd_en;
  logic [SW-1:0]    rd_addr;
  logic [SLOTS-1:0] rd_data;
  logic             wr_en;
  logic [SW-1:0]    wr_addr;
  logic [SLOTS-1:0] wr_data;
  logic             out_valid_r;
  status_t          out_status_r;

  wfg_ctrl #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_slot   (in_tdata[SlotW-1:0]),
    .in_mask   (in_tdata[SlotW+MaskW-1:SlotW]),
    .res       (res),
    .res_ready (res_ready),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  wfg_row_mem #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW - 2){1'b0}}, out_status_r};

endmodule

`default_nettype wire

[rtl/wfg_row_mem.sv]
// Adjacency row memory: one write port and one registered read port.
`default_nettype none

module wfg_row_mem #(
  parameter int SLOTS = wfg_pkg::DefaultSlots,
  parameter int SW    = $clog2(SLOTS)
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [SW-1:0]    rd_addr,
  output logic      [SLOTS-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [SW-1:0]    wr_addr,
  input  wire logic [SLOTS-1:0] wr_data
);

  logic [SLOTS-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/wfg_ctrl.sv]
// Sequencer for slot entry, cycle walk over the rows and column clearing sweep.
`default_nettype none

module wfg_ctrl #(
  parameter int SLOTS = wfg_pkg::DefaultSlots,
  parameter int SW    = $clog2(SLOTS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_action,
  input  wire logic [wfg_pkg::SlotW-1:0]  in_slot,
  input  wire logic [wfg_pkg::MaskW-1:0]  in_mask,
  output wfg_pkg::wfg_res_t               res,
  input  wire logic                       res_ready,
  output logic                            rd_en,
  output logic      [SW-1:0]              rd_addr,
  input  wire logic [SLOTS-1:0]           rd_data,
  output logic                            wr_en,
  output logic      [SW-1:0]              wr_addr,
  output logic      [SLOTS-1:0]           wr_data
);

  import wfg_pkg::*;

  localparam int PW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_DATA,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [SLOTS-1:0] present_r, present_nxt;
  logic [SLOTS-1:0] reach_r, reach_nxt;
  logic [SLOTS-1:0] visited_r, visited_nxt;
  status_t          status_r, status_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic [SW-1:0]    rd_addr_r, rd_addr_nxt;

  logic [SW-1:0]    s_in;
  logic [SLOTS-1:0] sbit_in;
  logic [SLOTS-1:0] sbit;
  logic [SLOTS-1:0] row_in;
  logic [SLOTS-1:0] pending;
  logic [SW-1:0]    pick;
  logic [SLOTS-1:0] swept_row;
  logic             in_range;

  assign s_in      = SW'(in_slot);
  assign sbit_in   = SLOTS'(1) << s_in;
  assign sbit      = SLOTS'(1) << slot_r;
  assign row_in    = SLOTS'(in_mask);
  assign in_range  = int'(in_slot) < SLOTS;
  assign pending   = reach_r & ~visited_r;
  assign swept_row = rd_data & ~sbit;

  always_comb begin
    pick = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    present_nxt = present_r;
    reach_nxt   = reach_r;
    visited_nxt = visited_r;
    status_nxt  = status_r;
    ptr_nxt     = ptr_r;
    rd_pend_nxt = 1'b0;
    rd_addr_nxt = rd_addr_r;
    in_ready    = 1'b0;
    res.valid   = 1'b0;
    res.status  = status_r;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          slot_nxt   = s_in;
          status_nxt = ST_OK;
          ptr_nxt    = '0;
          state_nxt  = S_DONE;
          if (in_range) begin
            if (in_action == ActAdd) begin
              if ((present_r & sbit_in) != '0) begin
                status_nxt = ST_ALREADY_WAITING;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = s_in;
                wr_data     = row_in;
                present_nxt = present_r | sbit_in;
                reach_nxt   = row_in & present_r & ~sbit_in;
                visited_nxt = '0;
                state_nxt   = S_WALK_RD;
              end
            end else begin
              if ((present_r & sbit_in) != '0) begin
                status_nxt = ST_COMMIT_WAITING;
              end else begin
                state_nxt = S_SWEEP;
              end
            end
          end
        end
      end
      S_WALK_RD: begin
        if ((reach_r & sbit) != '0) begin
          present_nxt = present_r & ~sbit;
          status_nxt  = ST_DEADLOCK;
          ptr_nxt     = '0;
          state_nxt   = S_SWEEP;
        end else if (pending == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_en                = 1'b1;
          rd_addr              = pick;
          visited_nxt[pick]    = 1'b1;
          state_nxt            = S_WALK_DATA;
        end
      end
      S_WALK_DATA: begin
        reach_nxt = reach_r | (rd_data & present_r);
        state_nxt = S_WALK_RD;
      end
      S_SWEEP: begin
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_addr = rd_addr_r;
          wr_data = swept_row;
          if (swept_row == '0) begin
            present_nxt[rd_addr_r] = 1'b0;
          end
        end
        if (ptr_r < PW'(SLOTS)) begin
          rd_en       = 1'b1;
          rd_addr     = ptr_r[SW-1:0];
          rd_addr_nxt = ptr_r[SW-1:0];
          rd_pend_nxt = 1'b1;
          ptr_nxt     = ptr_r + PW'(1);
        end else if (rd_pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      present_r <= '0;
      reach_r   <= '0;
      visited_r <= '0;
      ptr_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      present_r <= present_nxt;
      reach_r   <= reach_nxt;
      visited_r <= visited_nxt;
      ptr_r     <= ptr_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    status_r  <= status_nxt;
    rd_addr_r <= rd_addr_nxt;
  end

  a_reach_present: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK_RD |-> (reach_r & ~present_r) == '0)
    else $error("Cycle walk reached a slot that is not present.");

  a_visited_reached: assert property (@(posedge clk) disable iff (!rst_n)
    (visited_r & ~reach_r) == '0)
    else $error("A visited row lies outside the reach set.");

  a_deadlock_removed: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.status == ST_DEADLOCK |-> (present_r & sbit) == '0)
    else $error("Deadlocked slot still present at result time.");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PW'(SLOTS))
    else $error("Sweep pointer ran past the last row.");

endmodule

`default_nettype wire

[tb/wait_for_graph_deadlock_detector_tb.sv]
// Self-checking testbench for the wait-for graph deadlock detector with a built-in graph predictor.
`default_nettype none

module wait_for_graph_deadlock_detector_tb;
  import wfg_pkg::*;

  typedef struct packed {
    logic            act;
    logic [SlotW-1:0] slot;
    logic [MaskW-1:0] mask;
  } wait_item_t;

  localparam int ItemCount  = 1050;
  localparam int QuietLimit = 3000;
  localparam int DrainWait  = 150;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  wait_item_t  pending_q[$];
  status_t     due_status_q[$];
  logic [31:0] wait_row[32];
  logic [31:0] present_set = '0;
  logic [31:0] reach_set   = '0;

  bit in_fire   = 1'b0;
  bit calm      = 1'b0;
  int in_gap    = 0;
  int ready_hold = 0;
  int made_cnt  = 0;
  int taken_cnt = 0;
  int quiet_cnt = 0;
  int mismatch_cnt = 0;

  wait_for_graph_deadlock_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Removes one slot from every row, drops present slots whose row is left empty and clears the rows of absent slots.
  task automatic sweep_column(input logic [SlotW-1:0] col);
    for (int t = 0; t < 32; t++) begin
      wait_row[t][col] = 1'b0;
      if (present_set[t] && wait_row[t] == '0) present_set[t] = 1'b0;
      if (!present_set[t]) wait_row[t] = '0;
    end
  endtask

  task automatic apply_wait_item(input wait_item_t it, output status_t st);
    logic [31:0] sbit;
    logic [31:0] reach;
    logic [31:0] prev;
    sbit = 32'b1 << it.slot;
    st = ST_OK;
    if (it.act == ActAdd) begin
      if ((present_set & sbit) != '0) begin
        st = ST_ALREADY_WAITING;
      end else begin
        present_set |= sbit;
        wait_row[it.slot] = it.mask;
        reach = it.mask & present_set & ~sbit;
        do begin
          prev = reach;
          for (int t = 0; t < 32; t++) begin
            if (reach[t]) reach |= wait_row[t] & present_set;
          end
        end while (reach != prev);
        reach_set = reach;
        if ((reach & sbit) != '0) begin
          present_set &= ~sbit;
          wait_row[it.slot] = '0;
          sweep_column(it.slot);
          st = ST_DEADLOCK;
        end
      end
    end else if ((present_set & sbit) != '0) begin
      st = ST_COMMIT_WAITING;
    end else begin
      sweep_column(it.slot);
    end
  endtask

  task automatic push_item(input logic act, input int slot, input logic [31:0] mask);
    wait_item_t it;
    it.act  = act;
    it.slot = slot[SlotW-1:0];
    it.mask = mask;
    pending_q.insert(pending_q.size(), it);
    made_cnt++;
  endtask

  always @(negedge clk) begin
    if (rst_n && (in_fire || !in_tvalid)) begin
      wait_item_t cur;
      in_fire = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur = pending_q.pop_front();
        in_tuser  <= cur.act;
        in_tdata  <= {3'b000, cur.mask, cur.slot};
        in_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (out_tready && !calm && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold = pick_gap();
    end else begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      wait_item_t it;
      status_t    st;
      status_t    want;
      bit         moved;
      moved = 1'b0;
      if (in_tvalid && in_tready) begin
        it.act  = in_tuser;
        it.slot = in_tdata[SlotW-1:0];
        it.mask = in_tdata[SlotW+MaskW-1:SlotW];
        apply_wait_item(it, st);
        due_status_q.insert(due_status_q.size(), st);
        taken_cnt++;
        in_fire = 1'b1;
        moved = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (due_status_q.size() == 0) begin
          report_mismatch("unexpected result, status", out_tdata[1:0], -1);
        end else begin
          want = due_status_q.pop_front();
          if (out_tdata[1:0] != want) report_mismatch("status", out_tdata[1:0], want);
        end
      end
      quiet_cnt = moved ? 0 : quiet_cnt + 1;
      if (quiet_cnt >= QuietLimit) begin
        $display("Timeout: no transaction for %0d cycles", QuietLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int pool;
    int slot;
    int r;
    int n;
    logic [31:0] mask;
    for (int t = 0; t < 32; t++) wait_row[t] = '0;

    push_item(ActCommit, 0, 32'h0);
    push_item(ActAdd, 0, 32'h0);
    push_item(ActAdd, 0, 32'h0);
    push_item(ActCommit, 0, 32'hFFFF_FFFF);
    push_item(ActAdd, 1, 32'h1 << 1);
    push_item(ActAdd, 2, 32'h1 << 3);
    push_item(ActAdd, 3, 32'h1 << 2);
    push_item(ActAdd, 31, 32'hFFFF_FFFF);
    push_item(ActAdd, 30, 32'h1 << 31);
    push_item(ActCommit, 31, 32'h0);
    push_item(ActAdd, 4, 32'h1 << 5);
    push_item(ActAdd, 5, 32'h1 << 6);
    push_item(ActAdd, 6, 32'h1 << 4);
    push_item(ActAdd, 7, 32'h1 << 8);
    push_item(ActCommit, 8, 32'h0);
    push_item(ActAdd, 31, 32'h0);
    push_item(ActCommit, 1, 32'h0);
    push_item(ActCommit, 30, 32'h0);
    push_item(ActAdd, 16, 32'hAAAA_AAAA);
    push_item(ActAdd, 17, 32'h5555_5555);
    push_item(ActCommit, 31, 32'h0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    pool = 32;
    for (int i = 0; i < ItemCount; i++) begin
      while (pending_q.size() >= 2) @(posedge clk);
      if (i % 60 == 0) begin
        r = $urandom_range(0, 3);
        pool = (r == 0) ? 4 : (r == 1) ? 8 : (r == 2) ? 16 : 32;
        calm = ($urandom_range(0, 3) == 0);
      end
      mask = '0;
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) mask[$urandom_range(0, pool - 1)] = 1'b1;
      slot = $urandom_range(0, pool - 1);
      r = $urandom_range(0, 99);
      if (r < 45) begin
        for (int k = 0; k < 8 && present_set[slot]; k++) slot = $urandom_range(0, pool - 1);
        push_item(ActAdd, slot, mask);
      end else if (r < 70) begin
        for (int k = 0; k < 8 && present_set[slot]; k++) slot = $urandom_range(0, pool - 1);
        push_item(ActCommit, slot, $urandom());
      end else if (r < 78) begin
        for (int k = 0; k < 8 && !present_set[slot]; k++) slot = $urandom_range(0, pool - 1);
        push_item(ActAdd, slot, mask);
      end else if (r < 85) begin
        for (int k = 0; k < 8 && !present_set[slot]; k++) slot = $urandom_range(0, pool - 1);
        push_item(ActCommit, slot, mask);
      end else if (r < 95) begin
        push_item(1'($urandom_range(0, 1)), $urandom_range(0, 31), $urandom());
      end else begin
        push_item(ActAdd, slot, 32'h0);
      end
    end

    while (taken_cnt < made_cnt || due_status_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/wfg_pkg.sv
rtl/wfg_row_mem.sv
rtl/wfg_ctrl.sv
rtl/wait_for_graph_deadlock_detector.sv
tb/wait_for_graph_deadlock_detector_tb.sv
